// File: sv/iale_pkg.sv
// Package for the indexed array list engine.
// Holds the sizing constants, the request kind codes and the word and control structs.
// No dependencies.
package iale_pkg;

	// List capacity, the widths that follow from it and the field widths
	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int POS_W    = 7;
	localparam int VAL_W    = 32;
	localparam int FOUND_W  = 6;
	localparam int ECNT_W   = 7;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Request kinds
	typedef enum logic [1:0] {
		KIND_APPEND = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_SEARCH = 2'd3
	} kind_t;

	// Request word
	typedef struct packed {
		kind_t                    kind;
		logic [POS_W-1:0]         position;
		logic signed [VAL_W-1:0]  value;
	} req_t;

	// Result word
	typedef struct packed {
		logic                     ok;
		logic [FOUND_W-1:0]       found_position;
		logic [ECNT_W-1:0]        entry_count;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic take;      // capture request, set walk index, clear result flags
		logic rd_cur;    // read entry at walk index
		logic rd_prev;   // read entry below walk index
		logic rd_next;   // read entry above walk index
		logic wr_shift;  // write read data at walk index
		logic wr_value;  // write request value at walk index
		logic idx_up;
		logic idx_dn;
		logic cnt_up;
		logic cnt_dn;
		logic pass;      // mark request as succeeded
		logic hit;       // mark search hit at walk index
		logic emit;      // load result word into output register
	} iale_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		kind_t kind;
		logic  room;       // count below capacity
		logic  ins_legal;  // position <= count
		logic  rem_legal;  // position < count
		logic  at_pos;     // walk index equals position
		logic  at_above;   // walk index equals position + 1
		logic  more1;      // walk index + 1 < count
		logic  more2;      // walk index + 2 < count
		logic  empty;
		logic  match;      // read data equals request value
		logic  out_free;
	} iale_stat_t;

endpackage

// File: sv/indexed_array_list_engine_top.sv
// Indexed array list engine: one request word at a time. Append, and insert at the end, write
// the value directly; other inserts first shift entries from position up one place, remove
// shifts the entries above position down, and search compares entries from the bottom up to
// the first match; refused requests only finish. Each moved or compared entry takes a RAM read
// step and then a write or compare step. The result word becomes valid as req_stall drops.
// Reset clears the entry count, controller and output valid; the entry RAM is not cleared.
module indexed_array_list_engine_top import iale_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	iale_cmd_t  cmd;
	iale_stat_t stat;

	// Sequencer
	iale_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Storage and result path
	iale_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// File: sv/iale_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module iale_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: sv/iale_datapath.sv
// Datapath of the indexed array list engine: entry RAM, count, walk index and result word.
// Depends on iale_pkg and iale_ram.
module iale_datapath import iale_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  req_t       req,
	input  logic       rsp_stall,
	input  iale_cmd_t  cmd,
	output iale_stat_t stat,
	output logic       rsp_valid,
	output rsp_t       rsp
);

	req_t               req_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic               ok_q;
	logic [FOUND_W-1:0] found_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic [VAL_W-1:0]   rd_data;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [VAL_W-1:0]   wr_data;
	logic [CNT_W-1:0]   rd_idx;

	// Entry store
	iale_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Pick read address around the walk index
	always_comb begin
		if (cmd.rd_prev) begin
			rd_idx = idx_q - CNT_W'(1);
		end else if (cmd.rd_next) begin
			rd_idx = idx_q + CNT_W'(1);
		end else begin
			rd_idx = idx_q;
		end
	end

	assign rd_en   = cmd.rd_cur | cmd.rd_prev | cmd.rd_next;
	assign rd_addr = IDX_W'(rd_idx);
	assign wr_en   = cmd.wr_shift | cmd.wr_value;
	assign wr_addr = IDX_W'(idx_q);
	assign wr_data = cmd.wr_shift ? rd_data : req_q.value;

	// Status towards the controller
	always_comb begin
		stat.kind      = req_q.kind;
		stat.room      = count_q < CNT_W'(CAPACITY);
		stat.ins_legal = CMP_W'(req_q.position) <= CMP_W'(count_q);
		stat.rem_legal = CMP_W'(req_q.position) < CMP_W'(count_q);
		stat.at_pos    = CMP_W'(idx_q) == CMP_W'(req_q.position);
		stat.at_above  = (CMP_W+1)'(idx_q) ==
			((CMP_W+1)'(req_q.position) + (CMP_W+1)'(1));
		stat.more1     = ((CNT_W+1)'(idx_q) + (CNT_W+1)'(1)) < (CNT_W+1)'(count_q);
		stat.more2     = ((CNT_W+2)'(idx_q) + (CNT_W+2)'(2)) < (CNT_W+2)'(count_q);
		stat.empty     = count_q == '0;
		stat.match     = rd_data == req_q.value;
		stat.out_free  = !rsp_valid_q || !rsp_stall;
	end

	// Capture request payload
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_q <= req;
		end
	end

	// Advance walk index and result flags
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			case (req.kind)
				KIND_REMOVE: idx_q <= CNT_W'(req.position);
				KIND_SEARCH: idx_q <= '0;
				default:     idx_q <= count_q;
			endcase
			ok_q    <= 1'b0;
			found_q <= '0;
		end else begin
			if (cmd.idx_up) begin
				idx_q <= idx_q + CNT_W'(1);
			end else if (cmd.idx_dn) begin
				idx_q <= idx_q - CNT_W'(1);
			end
			if (cmd.pass) begin
				ok_q <= 1'b1;
			end
			if (cmd.hit) begin
				ok_q    <= 1'b1;
				found_q <= FOUND_W'(idx_q);
			end
		end
	end

	// Hold entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_up) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.cnt_dn) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// Output register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.ok             <= ok_q;
			rsp_q.found_position <= found_q;
			rsp_q.entry_count    <= ECNT_W'(count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: sv/iale_ctrl.sv
// Controller of the indexed array list engine: sequences append, insert, remove and search.
// Depends on iale_pkg.
module iale_ctrl import iale_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  iale_stat_t stat,
	output iale_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_INS_RD,
		ST_INS_WR,
		ST_INS_PUT,
		ST_REM_RD,
		ST_REM_WR,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   stall_q;
	logic   stall_d;

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		stall_d = stall_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.take = 1'b1;
					stall_d  = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				state_d = ST_FIN;
				case (stat.kind)
					KIND_APPEND: begin
						if (stat.room) begin
							cmd.wr_value = 1'b1;
							cmd.cnt_up   = 1'b1;
							cmd.pass     = 1'b1;
						end
					end
					KIND_INSERT: begin
						if (stat.room && stat.ins_legal) begin
							if (stat.at_pos) begin
								cmd.wr_value = 1'b1;
								cmd.cnt_up   = 1'b1;
								cmd.pass     = 1'b1;
							end else begin
								state_d = ST_INS_RD;
							end
						end
					end
					KIND_REMOVE: begin
						if (stat.rem_legal) begin
							if (stat.more1) begin
								state_d = ST_REM_RD;
							end else begin
								cmd.cnt_dn = 1'b1;
								cmd.pass   = 1'b1;
							end
						end
					end
					KIND_SEARCH: begin
						if (!stat.empty) begin
							state_d = ST_SRCH_RD;
						end
					end
					default: begin
						state_d = ST_FIN;
					end
				endcase
			end
			// Shift entries up one place, top down
			ST_INS_RD: begin
				cmd.rd_prev = 1'b1;
				state_d     = ST_INS_WR;
			end
			ST_INS_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_dn   = 1'b1;
				state_d      = stat.at_above ? ST_INS_PUT : ST_INS_RD;
			end
			ST_INS_PUT: begin
				cmd.wr_value = 1'b1;
				cmd.cnt_up   = 1'b1;
				cmd.pass     = 1'b1;
				state_d      = ST_FIN;
			end
			// Shift entries down one place, bottom up
			ST_REM_RD: begin
				cmd.rd_next = 1'b1;
				state_d     = ST_REM_WR;
			end
			ST_REM_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_up   = 1'b1;
				if (stat.more2) begin
					state_d = ST_REM_RD;
				end else begin
					cmd.cnt_dn = 1'b1;
					cmd.pass   = 1'b1;
					state_d    = ST_FIN;
				end
			end
			// Scan entries from the bottom for the first match
			ST_SRCH_RD: begin
				cmd.rd_cur = 1'b1;
				state_d    = ST_SRCH_CMP;
			end
			ST_SRCH_CMP: begin
				if (stat.match) begin
					cmd.hit = 1'b1;
					state_d = ST_FIN;
				end else if (stat.more1) begin
					cmd.idx_up = 1'b1;
					state_d    = ST_SRCH_RD;
				end else begin
					state_d = ST_FIN;
				end
			end
			// Hand the result word over once the output register is free
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					stall_d  = 1'b0;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				stall_d = 1'b0;
			end
		endcase
	end

	// Hold state and registered stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stall_q <= 1'b0;
		end else begin
			state_q <= state_d;
			stall_q <= stall_d;
		end
	end

	assign req_stall = stall_q;

endmodule
